// ----- sv/sfpf_pkg.sv -----
package sfpf_pkg;

  localparam int DATA_W = 8;
  localparam int CNT_W  = 9;
  localparam int DEPTH  = 256;

  localparam logic [DATA_W-1:0] DUTY_RESET  = 8'd240;
  localparam logic [CNT_W-1:0]  LIMIT_RESET = 9'd128;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_PERIOD = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic store;
    logic toggle;
    logic pop_start;
    logic pop_finish;
    logic set_underflow;
    logic load_rsp;
  } cmd_t;

  typedef struct packed {
    logic store_ok;
    logic pop_due;
    logic empty;
  } status_t;

endpackage

// ----- sv/sample_fifo_pwm_feeder_top.sv -----
// Channel   Handshake               Payload
// request   req_valid / req_stall   func, sample
// response  rsp_valid / rsp_stall   accepted, duty, duty_updated, underflow, fill_level
// config    cfg_wr_en               cfg_wr_data (accept_limit)
//
// Sample request: accepted back to back while the response register drains.
// Period request that pops: passes through ST_READ for the registered read of the sample RAM.
// Other period requests: answered from ST_IDLE without a RAM read.
// Synchronous active-high reset; no clearing pass, the RAM is written before it is read.
// A held response stalls requests only when rsp_stall is high.
module sample_fifo_pwm_feeder_top import sfpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic              func,
  input  logic [DATA_W-1:0] sample,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic              accepted,
  output logic [DATA_W-1:0] duty,
  output logic              duty_updated,
  output logic              underflow,
  output logic [CNT_W-1:0]  fill_level,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data
);

  cmd_t    cmd;
  status_t status;

  sfpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sfpf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .accepted     (accepted),
    .duty         (duty),
    .duty_updated (duty_updated),
    .underflow    (underflow),
    .fill_level   (fill_level)
  );

endmodule

// ----- sv/sfpf_ram.sv -----
module sfpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/sfpf_datapath.sv -----
module sfpf_datapath import sfpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [DATA_W-1:0] sample,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  output logic              accepted,
  output logic [DATA_W-1:0] duty,
  output logic              duty_updated,
  output logic              underflow,
  output logic [CNT_W-1:0]  fill_level
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0]     wr_ptr, wr_ptr_next;
  logic [AW-1:0]     rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              phase, phase_next;
  logic [DATA_W-1:0] duty_reg, duty_reg_next;
  logic              uf, uf_next;
  logic [CNT_W-1:0]  limit;
  logic [DATA_W-1:0] rdata;

  sfpf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wr_ptr),
    .wdata (sample),
    .re    (cmd.pop_start),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  assign status.store_ok = (count < limit) && (int'(count) < DEPTH);
  assign status.pop_due  = !phase;
  assign status.empty    = (count == '0);

  always_comb begin
    wr_ptr_next   = wr_ptr;
    rd_ptr_next   = rd_ptr;
    count_next    = count;
    phase_next    = phase;
    duty_reg_next = duty_reg;
    uf_next       = uf;
    if (cmd.store) begin
      wr_ptr_next = (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      count_next  = count + 1'b1;
    end
    if (cmd.toggle) begin
      phase_next = !phase;
    end
    if (cmd.set_underflow) begin
      uf_next = 1'b1;
    end
    if (cmd.pop_finish) begin
      rd_ptr_next   = (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      count_next    = count - 1'b1;
      duty_reg_next = rdata;
      uf_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      phase    <= 1'b0;
      duty_reg <= DUTY_RESET;
      uf       <= 1'b0;
      limit    <= LIMIT_RESET;
    end else begin
      wr_ptr   <= wr_ptr_next;
      rd_ptr   <= rd_ptr_next;
      count    <= count_next;
      phase    <= phase_next;
      duty_reg <= duty_reg_next;
      uf       <= uf_next;
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      accepted     <= cmd.store;
      duty         <= duty_reg_next;
      duty_updated <= cmd.pop_finish;
      underflow    <= uf_next;
      fill_level   <= count_next;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("fill count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_start |-> !status.empty)
    else $error("pop from empty buffer");

  a_pop_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_finish |-> $past(cmd.pop_start))
    else $error("pop finished without read");
`endif

endmodule

// ----- sv/sfpf_ctrl.sv -----
module sfpf_ctrl import sfpf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  logic    func,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   req_take;

  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign req_take  = req_valid && !req_stall;

  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid && rsp_stall;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          if (func == FUNC_SAMPLE) begin
            cmd.store      = status.store_ok;
            cmd.load_rsp   = 1'b1;
            rsp_valid_next = 1'b1;
          end else begin
            cmd.toggle = 1'b1;
            if (status.pop_due && !status.empty) begin
              cmd.pop_start = 1'b1;
              state_next    = ST_READ;
            end else begin
              cmd.set_underflow = status.pop_due;
              cmd.load_rsp      = 1'b1;
              rsp_valid_next    = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        cmd.pop_finish = 1'b1;
        cmd.load_rsp   = 1'b1;
        rsp_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

`ifndef SYNTH
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !rsp_valid)
    else $error("response register busy during pop");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_IDLE && rsp_valid)
    else $error("pop did not complete");

  a_sample_rsp: assert property (@(posedge clk) disable iff (rst)
    req_take && func == FUNC_SAMPLE |=> rsp_valid && state == ST_IDLE)
    else $error("sample request without response");
`endif

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import sfpf_pkg::*;

  localparam int FIFO_DEPTH = DEPTH;
  localparam int AW = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] duty;
    logic              duty_updated;
    logic              underflow;
    logic [CNT_W-1:0]  fill_level;
  } feeder_reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic              func = FUNC_SAMPLE;
  logic [DATA_W-1:0] sample = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic              accepted;
  logic [DATA_W-1:0] duty;
  logic              duty_updated;
  logic              underflow;
  logic [CNT_W-1:0]  fill_level;
  logic              cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data = '0;

  sample_fifo_pwm_feeder_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .func        (func),
    .sample      (sample),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .accepted    (accepted),
    .duty        (duty),
    .duty_updated(duty_updated),
    .underflow   (underflow),
    .fill_level  (fill_level),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the feeder
  logic [DATA_W-1:0] model_mem [FIFO_DEPTH];
  int unsigned       model_wr_ptr = 0;
  int unsigned       model_rd_ptr = 0;
  int unsigned       model_fill = 0;
  logic              model_phase = 1'b0;
  logic [DATA_W-1:0] model_duty = DUTY_RESET;
  logic              model_underflow = 1'b0;
  logic [CNT_W-1:0]  model_limit = LIMIT_RESET;

  feeder_reply_t expected_replies[$];
  int            error_count = 0;
  bit            idle_on = 1'b1;
  int            hold_request = 0;

  function automatic feeder_reply_t advance_feeder(input logic f, input logic [DATA_W-1:0] s);
    feeder_reply_t r;
    r.accepted = 1'b0;
    r.duty_updated = 1'b0;
    if (f == FUNC_SAMPLE) begin
      if (model_fill < int'(model_limit) && model_fill < FIFO_DEPTH) begin
        model_mem[model_wr_ptr[AW-1:0]] = s;
        model_wr_ptr = (model_wr_ptr + 1) % FIFO_DEPTH;
        model_fill++;
        r.accepted = 1'b1;
      end
    end else begin
      model_phase = ~model_phase;
      if (model_phase) begin
        if (model_fill != 0) begin
          model_duty = model_mem[model_rd_ptr[AW-1:0]];
          model_rd_ptr = (model_rd_ptr + 1) % FIFO_DEPTH;
          model_fill--;
          model_underflow = 1'b0;
          r.duty_updated = 1'b1;
        end else begin
          model_underflow = 1'b1;
        end
      end
    end
    r.duty = model_duty;
    r.underflow = model_underflow;
    r.fill_level = model_fill[CNT_W-1:0];
    return r;
  endfunction

  // mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_event(input logic f, input logic [DATA_W-1:0] s);
    int gap;
    gap = idle_on ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid = 1'b1;
    func = f;
    sample = s;
    do @(posedge clk); while (req_stall);
    expected_replies.push_back(advance_feeder(f, s));
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid = 1'b0;
    wait (expected_replies.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] value);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    model_limit = value;
  endtask

  // response side stall
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        rsp_stall = 1'b1;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
        rsp_stall = 1'b0;
      end else if (!idle_on) begin
        rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
        rsp_stall = 1'b1;
        stall_left--;
      end else begin
        rsp_stall = 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    feeder_reply_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("response with no request pending");
      end else begin
        want = expected_replies.pop_front();
        if (accepted !== want.accepted)
          report_mismatch($sformatf("accepted got %0d want %0d", accepted, want.accepted));
        if (duty !== want.duty)
          report_mismatch($sformatf("duty got %0d want %0d", duty, want.duty));
        if (duty_updated !== want.duty_updated)
          report_mismatch($sformatf("duty_updated got %0d want %0d", duty_updated,
                                    want.duty_updated));
        if (underflow !== want.underflow)
          report_mismatch($sformatf("underflow got %0d want %0d", underflow, want.underflow));
        if (fill_level !== want.fill_level)
          report_mismatch($sformatf("fill_level got %0d want %0d", fill_level,
                                    want.fill_level));
      end
    end
  end

  task automatic test_directed();
    send_event(FUNC_PERIOD, 8'h00);  // pop on empty buffer
    send_event(FUNC_PERIOD, 8'hFF);  // off-phase period
    send_event(FUNC_PERIOD, 8'h3C);
    send_event(FUNC_SAMPLE, 8'h00);
    send_event(FUNC_PERIOD, 8'hFF);  // underflow holds
    send_event(FUNC_PERIOD, 8'h00);  // pop clears underflow
    send_event(FUNC_SAMPLE, 8'hFF);
    send_event(FUNC_SAMPLE, 8'hA5);
    send_event(FUNC_SAMPLE, 8'h5A);
    send_event(FUNC_SAMPLE, 8'h80);
    send_event(FUNC_SAMPLE, 8'h01);
    repeat (12) send_event(FUNC_PERIOD, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_limit_edges();
    write_limit(9'd0);
    send_event(FUNC_SAMPLE, 8'hFF);
    send_event(FUNC_SAMPLE, 8'h00);
    send_event(FUNC_SAMPLE, 8'($urandom_range(0, 255)));
    repeat (4) send_event(FUNC_PERIOD, 8'($urandom_range(0, 255)));
    write_limit(9'd1);
    send_event(FUNC_SAMPLE, 8'h7E);
    send_event(FUNC_SAMPLE, 8'h81);
    repeat (2) send_event(FUNC_PERIOD, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_buffer_full();
    write_limit(9'h1FF);  // limit above depth
    repeat (FIFO_DEPTH + 2) send_event(FUNC_SAMPLE, 8'($urandom_range(0, 255)));
    repeat (6) send_event(FUNC_PERIOD, 8'($urandom_range(0, 255)));
    repeat (4) send_event(FUNC_SAMPLE, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_backpressure();
    drain();
    idle_on = 1'b0;
    hold_request = 150;
    repeat (40)
      send_event($urandom_range(0, 1) ? FUNC_PERIOD : FUNC_SAMPLE,
                 8'($urandom_range(0, 255)));
    idle_on = 1'b1;
  endtask

  task automatic test_random_phase(input logic [CNT_W-1:0] limit, input int count,
                                   input int sample_pct);
    logic f;
    write_limit(limit);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) idle_on = ($urandom_range(0, 4) != 0);
      f = ($urandom_range(0, 99) < sample_pct) ? FUNC_SAMPLE : FUNC_PERIOD;
      send_event(f, 8'($urandom_range(0, 255)));
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_limit_edges();
    test_buffer_full();
    test_backpressure();
    test_random_phase(9'd255, 180, 40);
    test_random_phase(9'd4, 150, 50);
    test_random_phase(9'd256, 220, 65);
    test_random_phase(9'd1, 100, 45);
    test_random_phase(9'($urandom_range(0, 256)), 180, 50);
    test_random_phase(LIMIT_RESET, 80, 35);
    drain();
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
